// File: design/kmd_pkg.sv
// Shared constants and types for the key matrix debouncer.
// Used by the top level, the row update logic and the port checker.
// No dependencies.
`default_nettype none

package kmd_pkg;

    localparam int DEFAULT_ROWS = 4;
    localparam int DEFAULT_COLS = 6;

    localparam int ROW_W   = 2;   // row_index / row_number width
    localparam int LEVEL_W = 6;   // column_levels / debounced_row width
    localparam int TIME_W  = 32;  // millisecond time width
    localparam int DELAY_W = 8;   // debounce delay register width

    localparam logic [DELAY_W-1:0] RESET_HOLD_MS = 8'd5;

    // Status of one row update handed back to the pipeline.
    typedef struct packed {
        logic [LEVEL_W-1:0] keys;
        logic               changed;
    } kmd_row_status_t;

endpackage

`default_nettype wire

// File: design/kmd_row_update.sv
// Per-key debounce update for one row of the key matrix.
// Takes the stored row entry and a new sample, returns the updated entry.
// Depends on kmd_pkg.
`default_nettype none

module kmd_row_update #(
    parameter int COLS = kmd_pkg::DEFAULT_COLS
) (
    input  wire logic [COLS-1:0]                   old_raw,
    input  wire logic [COLS-1:0]                   old_deb,
    input  wire logic [COLS*kmd_pkg::TIME_W-1:0]   old_time,
    input  wire logic [kmd_pkg::LEVEL_W-1:0]       column_levels,
    input  wire logic [kmd_pkg::TIME_W-1:0]        now_ms,
    input  wire logic [kmd_pkg::DELAY_W-1:0]       delay_ms,
    output logic      [COLS-1:0]                   new_raw,
    output logic      [COLS-1:0]                   new_deb,
    output logic      [COLS*kmd_pkg::TIME_W-1:0]   new_time,
    output kmd_pkg::kmd_row_status_t               status
);
    import kmd_pkg::*;

    logic [COLS+LEVEL_W-1:0] levels_ext;
    logic [COLS-1:0]         pressed;
    logic [COLS+LEVEL_W-1:0] keys_ext;

    // Columns beyond the sample width read as released (high).
    assign levels_ext = {{COLS{1'b1}}, column_levels};
    assign pressed    = ~levels_ext[COLS-1:0];

    always_comb
    begin
        logic [TIME_W-1:0] t_key;
        logic [TIME_W-1:0] held_ms;
        new_raw  = pressed;
        new_deb  = old_deb;
        new_time = old_time;
        for (int c = 0; c < COLS; c++)
        begin
            t_key = (pressed[c] != old_raw[c]) ? now_ms : old_time[c*TIME_W +: TIME_W];
            new_time[c*TIME_W +: TIME_W] = t_key;
            held_ms = now_ms - t_key;
            if (held_ms >= {{(TIME_W-DELAY_W){1'b0}}, delay_ms})
            begin
                new_deb[c] = pressed[c];
            end
        end
    end

    assign keys_ext       = {{LEVEL_W{1'b0}}, new_deb};
    assign status.keys    = keys_ext[LEVEL_W-1:0];
    assign status.changed = |(new_deb ^ old_deb);

endmodule

`default_nettype wire

// File: design/key_matrix_debouncer.sv
// Key matrix debouncer top level: row state memory, two-stage pipeline and
// result register. Depends on kmd_pkg and kmd_row_update.
//
// Usage: each transfer on the sample channel (sample_valid / sample_stall)
// carries one scanned row: row_index, active-low column_levels and now_ms.
// Each sample yields exactly one transfer on the result channel
// (result_valid / result_stall) with the row's debounced keys, a row-changed
// flag and a scan-changed flag that restarts whenever row zero is reported.
// The user must write the debounce delay through hold_delay_we only while
// idle; the block does not enforce it. A sample goes through the first-stage
// registers, then the result register. Throughput: one sample per cycle
// unless the result is stalled, set by the read-modify-write of the row
// memory; a write-to-read bypass covers back-to-back samples of the same row.
// Reset: the delay returns to 5 ms, the scan flag clears and a per-row valid
// bit marks every row as all released; there is no clearing pass, so samples
// are taken from the first cycle after reset.
// Stall: a stalled result holds; one further sample is still taken into the
// pipeline, after which sample_stall rises until the result is taken.
`default_nettype none

module key_matrix_debouncer #(
    parameter int ROWS = kmd_pkg::DEFAULT_ROWS,
    parameter int COLS = kmd_pkg::DEFAULT_COLS
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           hold_delay_we,
    input  wire logic [kmd_pkg::DELAY_W-1:0]    hold_delay_ms,
    input  wire logic                           sample_valid,
    output logic                                sample_stall,
    input  wire logic [kmd_pkg::ROW_W-1:0]      row_index,
    input  wire logic [kmd_pkg::LEVEL_W-1:0]    column_levels,
    input  wire logic [kmd_pkg::TIME_W-1:0]     now_ms,
    output logic                                result_valid,
    input  wire logic                           result_stall,
    output logic      [kmd_pkg::ROW_W-1:0]      row_number,
    output logic      [kmd_pkg::LEVEL_W-1:0]    debounced_row,
    output logic                                row_changed,
    output logic                                scan_changed
);
    import kmd_pkg::*;

    localparam int AW     = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int TIMES  = COLS * TIME_W;
    localparam int EW     = 2 * COLS + TIMES;

    // Entry layout: {change times, debounced keys, raw levels}.
    logic [EW-1:0] row_mem [ROWS];

    logic [DELAY_W-1:0] delay_reg;
    logic [ROWS-1:0]    row_valid_reg;
    logic               scan_acc_reg;

    logic               s1_valid_reg;
    logic [ROW_W-1:0]   s1_row_reg;
    logic               s1_in_range_reg;
    logic [AW-1:0]      s1_addr_reg;
    logic [LEVEL_W-1:0] s1_levels_reg;
    logic [TIME_W-1:0]  s1_now_reg;
    logic [EW-1:0]      rd_data_reg;
    logic               rd_known_reg;

    logic               result_valid_reg;
    logic [ROW_W-1:0]   row_number_reg;
    logic [LEVEL_W-1:0] debounced_row_reg;
    logic               row_changed_reg;
    logic               scan_changed_reg;

    logic               accept;
    logic               advance;
    logic               in_range;
    logic [AW-1:0]      rd_addr;
    logic               wr_en;
    logic               wr_hit;
    logic [EW-1:0]      cur_entry;
    logic [EW-1:0]      wr_data;
    logic [COLS-1:0]    new_raw;
    logic [COLS-1:0]    new_deb;
    logic [TIMES-1:0]   new_time;
    kmd_row_status_t    status;
    logic               scan_acc_next;

    assign advance      = s1_valid_reg && (!result_valid_reg || !result_stall);
    assign sample_stall = s1_valid_reg && !advance;
    assign accept       = sample_valid && !sample_stall;

    assign in_range = ({{(32-ROW_W){1'b0}}, row_index} < 32'(ROWS));
    assign rd_addr  = in_range ? AW'(row_index) : '0;

    // A row that was never written holds the reset state: all zero.
    assign cur_entry = rd_known_reg ? rd_data_reg : '0;

    kmd_row_update #(
        .COLS(COLS)
    ) u_row_update (
        .old_raw       (cur_entry[COLS-1:0]),
        .old_deb       (cur_entry[2*COLS-1:COLS]),
        .old_time      (cur_entry[EW-1:2*COLS]),
        .column_levels (s1_levels_reg),
        .now_ms        (s1_now_reg),
        .delay_ms      (delay_reg),
        .new_raw       (new_raw),
        .new_deb       (new_deb),
        .new_time      (new_time),
        .status        (status)
    );

    assign wr_data = {new_time, new_deb, new_raw};
    assign wr_en   = advance && s1_in_range_reg;
    assign wr_hit  = wr_en && (s1_addr_reg == rd_addr);

    always_comb
    begin
        if (!s1_in_range_reg)
        begin
            scan_acc_next = scan_acc_reg;
        end
        else if (s1_row_reg == '0)
        begin
            scan_acc_next = status.changed;
        end
        else
        begin
            scan_acc_next = scan_acc_reg | status.changed;
        end
    end

    // Row memory: one write and one registered read per cycle. A read of the
    // row being written in the same cycle takes the new entry.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            row_mem[s1_addr_reg] <= wr_data;
        end
        if (accept)
        begin
            rd_data_reg <= wr_hit ? wr_data : row_mem[rd_addr];
        end
    end

    // Pipeline payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_row_reg      <= row_index;
            s1_in_range_reg <= in_range;
            s1_addr_reg     <= rd_addr;
            s1_levels_reg   <= column_levels;
            s1_now_reg      <= now_ms;
        end
        if (advance)
        begin
            row_number_reg    <= s1_row_reg;
            debounced_row_reg <= s1_in_range_reg ? status.keys : '0;
            row_changed_reg   <= s1_in_range_reg && status.changed;
            scan_changed_reg  <= scan_acc_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg        <= RESET_HOLD_MS;
            row_valid_reg    <= '0;
            scan_acc_reg     <= 1'b0;
            s1_valid_reg     <= 1'b0;
            rd_known_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (hold_delay_we)
            begin
                delay_reg <= hold_delay_ms;
            end
            if (wr_en)
            begin
                row_valid_reg[s1_addr_reg] <= 1'b1;
            end
            if (accept)
            begin
                rd_known_reg <= row_valid_reg[rd_addr] || wr_hit;
            end
            if (advance)
            begin
                scan_acc_reg <= scan_acc_next;
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    assign result_valid  = result_valid_reg;
    assign row_number    = row_number_reg;
    assign debounced_row = debounced_row_reg;
    assign row_changed   = row_changed_reg;
    assign scan_changed  = scan_changed_reg;

endmodule

`default_nettype wire

// File: design/kmd_checker.sv
// Port-level checks for the key matrix debouncer, attached by bind.
// Sees only the top-level ports. Depends on kmd_pkg and key_matrix_debouncer.
`default_nettype none

module kmd_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           sample_stall,
    input wire logic                           result_valid,
    input wire logic                           result_stall,
    input wire logic [kmd_pkg::ROW_W-1:0]      row_number,
    input wire logic [kmd_pkg::LEVEL_W-1:0]    debounced_row,
    input wire logic                           row_changed,
    input wire logic                           scan_changed
);
    import kmd_pkg::*;

    // A stalled result stays and holds its payload.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=>
            result_valid && $stable(row_number) && $stable(debounced_row)
            && $stable(row_changed) && $stable(scan_changed))
        else $error("stalled result changed");

    // The sample side only backs up when a result is waiting and stalled.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> result_valid && result_stall)
        else $error("sample stall without a stalled result");

    // A changed row always shows in the scan flag.
    a_row_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && row_changed |-> scan_changed)
        else $error("row change missing from scan flag");

    // Row zero restarts the scan flag with its own change.
    a_row_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (row_number == '0) |-> scan_changed == row_changed)
        else $error("scan flag not restarted at row zero");

endmodule

bind key_matrix_debouncer kmd_checker u_kmd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .sample_stall  (sample_stall),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .row_number    (row_number),
    .debounced_row (debounced_row),
    .row_changed   (row_changed),
    .scan_changed  (scan_changed)
);

`default_nettype wire

// File: bench/key_matrix_debouncer_checker.sv
// Port checker for the key matrix debouncer: watches the configuration, sample
// and result ports, keeps its own copy of the per-key debounce state and
// compares every result transfer with the predicted row report. Uses kmd_pkg.
module key_matrix_debouncer_checker #(
    parameter int ROWS = kmd_pkg::DEFAULT_ROWS,
    parameter int COLS = kmd_pkg::DEFAULT_COLS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          hold_delay_we,
    input  logic [kmd_pkg::DELAY_W-1:0]   hold_delay_ms,
    input  logic                          sample_valid,
    input  logic                          sample_stall,
    input  logic [kmd_pkg::ROW_W-1:0]     row_index,
    input  logic [kmd_pkg::LEVEL_W-1:0]   column_levels,
    input  logic [kmd_pkg::TIME_W-1:0]    now_ms,
    input  logic                          result_valid,
    input  logic                          result_stall,
    input  logic [kmd_pkg::ROW_W-1:0]     row_number,
    input  logic [kmd_pkg::LEVEL_W-1:0]   debounced_row,
    input  logic                          row_changed,
    input  logic                          scan_changed,
    output int                            outstanding,
    output int                            failures
);
    timeunit 1ns;
    timeprecision 1ps;
    import kmd_pkg::*;

    typedef struct packed {
        logic [ROW_W-1:0]   row;
        logic [LEVEL_W-1:0] keys;
        logic               changed;
        logic               scan;
    } row_report_t;

    row_report_t        pending_reports[$];
    logic               raw_level   [ROWS][COLS];
    logic [TIME_W-1:0]  change_time [ROWS][COLS];
    logic               key_down    [ROWS][COLS];
    logic               scan_acc;
    logic [DELAY_W-1:0] hold_ms;
    int                 mismatch_count = 0;
    int                 awaiting = 0;

    assign failures    = mismatch_count;
    assign outstanding = awaiting;

    // Applies one row sample to the key state and returns the report it yields.
    function automatic row_report_t debounce_row_sample(
        input logic [ROW_W-1:0]   row,
        input logic [LEVEL_W-1:0] levels,
        input logic [TIME_W-1:0]  now
    );
        row_report_t       rep;
        logic              level;
        logic [TIME_W-1:0] held_for;
        rep = '0;
        rep.row = row;
        if (row < ROWS)
        begin
            for (int c = 0; c < COLS; c++)
            begin
                // Column pins are active low; a column past the field reads released.
                level = (c < LEVEL_W) ? ~levels[c] : 1'b0;
                if (level != raw_level[row][c])
                begin
                    raw_level[row][c]   = level;
                    change_time[row][c] = now;
                end
                // Wrapping subtraction keeps the hold time right across a time wrap.
                held_for = now - change_time[row][c];
                if (held_for >= hold_ms && key_down[row][c] != level)
                begin
                    key_down[row][c] = level;
                    rep.changed      = 1'b1;
                end
                if (c < LEVEL_W)
                    rep.keys[c] = key_down[row][c];
            end
            scan_acc = (row == 0) ? rep.changed : (scan_acc | rep.changed);
        end
        rep.scan = scan_acc;
        return rep;
    endfunction

    function automatic void check_field(input string field, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        row_report_t want;
        if (!rst_n)
        begin
            for (int r = 0; r < ROWS; r++)
            begin
                for (int c = 0; c < COLS; c++)
                begin
                    raw_level[r][c]   = 1'b0;
                    change_time[r][c] = '0;
                    key_down[r][c]    = 1'b0;
                end
            end
            scan_acc = 1'b0;
            hold_ms  = RESET_HOLD_MS;
            pending_reports.delete();
            awaiting <= 0;
        end
        else
        begin
            if (hold_delay_we)
                hold_ms = hold_delay_ms;
            if (sample_valid && !sample_stall)
                pending_reports.push_back(debounce_row_sample(row_index, column_levels, now_ms));
            if (result_valid && !result_stall)
            begin
                if (pending_reports.size() == 0)
                begin
                    $display("%0t: result transfer with nothing expected, expected none, actual row %0d",
                             $time, row_number);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_reports.pop_front();
                    check_field("row_number", want.row, row_number);
                    check_field("debounced_row", want.keys, debounced_row);
                    check_field("row_changed", want.changed, row_changed);
                    check_field("scan_changed", want.scan, scan_changed);
                end
            end
            awaiting <= pending_reports.size();
        end
    end

endmodule

// File: bench/key_matrix_debouncer_tb.sv
// Testbench top for the key matrix debouncer: clock, reset, directed and
// random row samples, delay writes and the verdict. Depends on kmd_pkg,
// key_matrix_debouncer and key_matrix_debouncer_checker.
module key_matrix_debouncer_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import kmd_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 175;

    logic               clk;
    logic               rst_n;
    logic               hold_delay_we;
    logic [DELAY_W-1:0] hold_delay_ms;
    logic               sample_valid;
    logic               sample_stall;
    logic [ROW_W-1:0]   row_index;
    logic [LEVEL_W-1:0] column_levels;
    logic [TIME_W-1:0]  now_ms;
    logic               result_valid;
    logic               result_stall;
    logic [ROW_W-1:0]   row_number;
    logic [LEVEL_W-1:0] debounced_row;
    logic               row_changed;
    logic               scan_changed;
    int                 outstanding;
    int                 failures;

    int                 gap_odds   = 0;
    int                 stall_odds = 0;
    int                 cycle_count = 0;
    logic [TIME_W-1:0]  clock_ms;
    logic [LEVEL_W-1:0] held_levels [4];
    logic [LEVEL_W-1:0] bounce_mask [4];
    int                 bounce_left [4];

    key_matrix_debouncer i_dut (
        .clk                  (clk),
        .rst_n                (rst_n),
        .hold_delay_we        (hold_delay_we),
        .hold_delay_ms        (hold_delay_ms),
        .sample_valid         (sample_valid),
        .sample_stall         (sample_stall),
        .row_index            (row_index),
        .column_levels        (column_levels),
        .now_ms               (now_ms),
        .result_valid         (result_valid),
        .result_stall         (result_stall),
        .row_number           (row_number),
        .debounced_row        (debounced_row),
        .row_changed          (row_changed),
        .scan_changed         (scan_changed)
    );

    key_matrix_debouncer_checker i_checker (
        .clk                  (clk),
        .rst_n                (rst_n),
        .hold_delay_we        (hold_delay_we),
        .hold_delay_ms        (hold_delay_ms),
        .sample_valid         (sample_valid),
        .sample_stall         (sample_stall),
        .row_index            (row_index),
        .column_levels        (column_levels),
        .now_ms               (now_ms),
        .result_valid         (result_valid),
        .result_stall         (result_stall),
        .row_number           (row_number),
        .debounced_row        (debounced_row),
        .row_changed          (row_changed),
        .scan_changed         (scan_changed),
        .outstanding          (outstanding),
        .failures             (failures)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Result side: random stall bursts whenever stall_odds is nonzero.
    initial
    begin
        result_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1)
            begin
                result_stall <= 1'b1;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
            result_stall <= 1'b0;
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    // Drives one row sample and returns at the edge where it is transferred.
    task automatic send_sample(input logic [ROW_W-1:0] row, input logic [LEVEL_W-1:0] levels,
                               input logic [TIME_W-1:0] stamp);
        if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
        begin
            sample_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        sample_valid  <= 1'b1;
        row_index     <= row;
        column_levels <= levels;
        now_ms        <= stamp;
        do
            @(posedge clk);
        while (sample_stall);
    endtask

    // Waits for the block to drain, then writes a new debounce delay.
    task automatic settle_and_set_delay(input logic [DELAY_W-1:0] delay);
        sample_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (4) @(posedge clk);
        hold_delay_we <= 1'b1;
        hold_delay_ms <= delay;
        @(posedge clk);
        hold_delay_we <= 1'b0;
    endtask

    // Mostly in-order scans of held key patterns with short bounce bursts,
    // plus occasional out-of-order rows, time jumps and noise samples.
    task automatic random_scans(input int count, input int step_max);
        int                 issued;
        int                 next_row;
        logic [ROW_W-1:0]   row;
        logic [LEVEL_W-1:0] levels;
        logic [LEVEL_W-1:0] flips;
        issued   = 0;
        next_row = 0;
        while (issued < count)
        begin
            if ($urandom_range(0, 99) < 85)
            begin
                row      = ROW_W'(next_row);
                next_row = (next_row + 1) % 4;
            end
            else
                row = ROW_W'($urandom_range(0, 3));
            clock_ms += $urandom_range(0, step_max);
            if ($urandom_range(0, 199) == 0)
                clock_ms = $urandom;
            if ($urandom_range(0, 24) == 0)
            begin
                if ($urandom_range(0, 1) == 0)
                    flips = LEVEL_W'(1) << $urandom_range(0, LEVEL_W - 1);
                else
                    flips = LEVEL_W'($urandom_range(1, 63));
                held_levels[row] ^= flips;
                bounce_mask[row]  = flips;
                bounce_left[row]  = $urandom_range(0, 6);
            end
            levels = held_levels[row];
            if (bounce_left[row] > 0)
            begin
                levels ^= LEVEL_W'($urandom) & bounce_mask[row];
                bounce_left[row]--;
            end
            if ($urandom_range(0, 49) == 0)
                levels = LEVEL_W'($urandom);
            send_sample(row, levels, clock_ms);
            issued++;
        end
    endtask

    function automatic int pick_odds();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 3;
            default: return 12;
        endcase
    endfunction

    initial
    begin
        int          phase_delay [PHASES];
        int          delay;
        rst_n         = 1'b0;
        hold_delay_we = 1'b0;
        hold_delay_ms = '0;
        sample_valid  = 1'b0;
        row_index     = '0;
        column_levels = '1;
        now_ms        = '0;
        for (int r = 0; r < 4; r++)
        begin
            held_levels[r] = '1;
            bounce_mask[r] = '0;
            bounce_left[r] = 0;
        end
        phase_delay = '{1, 255, 0, 3, -1, -1, 12, 5};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        gap_odds   = 6;
        stall_odds = 6;
        // Default delay of 5 ms: press, hold, scan flag restart and bounce.
        send_sample(2'd0, 6'b111111, 32'd0);
        send_sample(2'd0, 6'b000000, 32'd1);
        send_sample(2'd1, 6'b101010, 32'd1);
        send_sample(2'd0, 6'b000000, 32'd4);
        send_sample(2'd0, 6'b000000, 32'd6);
        send_sample(2'd1, 6'b101010, 32'd6);
        send_sample(2'd2, 6'b111111, 32'd6);
        send_sample(2'd3, 6'b111111, 32'd7);
        send_sample(2'd0, 6'b000000, 32'd7);
        send_sample(2'd0, 6'b111111, 32'd7);
        send_sample(2'd0, 6'b000000, 32'd8);
        send_sample(2'd3, 6'b011111, 32'd8);
        send_sample(2'd3, 6'b011111, 32'd13);
        // Hold time measured across the wrap of the millisecond counter.
        send_sample(2'd2, 6'b111110, 32'hFFFF_FFFE);
        send_sample(2'd2, 6'b111110, 32'd3);
        send_sample(2'd1, 6'b111111, 32'hFFFF_FFFF);
        send_sample(2'd1, 6'b111111, 32'd3);
        send_sample(2'd1, 6'b111111, 32'd4);
        // Zero delay: a new level is taken on the sample that shows it.
        settle_and_set_delay(8'd0);
        send_sample(2'd0, 6'b111111, 32'd100);
        send_sample(2'd0, 6'b000000, 32'd100);
        send_sample(2'd3, 6'b111111, 32'd100);
        // Largest delay, just short of and exactly at the hold time.
        settle_and_set_delay(8'd255);
        send_sample(2'd0, 6'b111111, 32'd200);
        send_sample(2'd0, 6'b111111, 32'd454);
        send_sample(2'd0, 6'b111111, 32'd455);

        clock_ms = 32'd500;
        for (int p = 0; p < PHASES; p++)
        begin
            delay = (phase_delay[p] < 0) ? $urandom_range(0, 255) : phase_delay[p];
            settle_and_set_delay(DELAY_W'(delay));
            if (p == PHASES - 1)
            begin
                gap_odds   = 0;
                stall_odds = 0;
            end
            else
            begin
                gap_odds   = pick_odds();
                stall_odds = pick_odds();
            end
            if (p == 3)
                clock_ms = 32'hFFFF_FF80;
            random_scans(PHASE_ITEMS, (delay >> 3) + 2);
        end

        sample_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (8) @(posedge clk);
        if (failures == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
